FILE: hw/rtl/vmp_pkg.sv
// Shared types, codes and defaults for the vector-matrix product block.
`timescale 1ns / 1ps

package vmp_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_LOAD_VECTOR = 2'd0;
   localparam logic [1:0] KIND_LOAD_MATRIX = 2'd1;
   localparam logic [1:0] KIND_START       = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_ROW_COUNT    = 1'b0;
   localparam logic CSR_COLUMN_COUNT = 1'b1;

   localparam int DEF_MAX_ROWS = 16;
   localparam int DEF_MAX_COLS = 16;

   localparam int VALUE_W = 16;
   localparam int PROD_W  = 32;
   localparam int SUM_W   = 40;
   localparam int REG_W   = 5;
   // Wide enough for any row or column index up to the largest store size.
   localparam int IDX_W   = 6;
   // Wide enough to hold a row count up to the largest store size.
   localparam int CNT_W   = 7;
   localparam int RESULT_LIMIT = 16;

   localparam logic [REG_W-1:0] ROW_COUNT_RESET    = 5'd16;
   localparam logic [REG_W-1:0] COLUMN_COUNT_RESET = 5'd16;

   // Store write and read controls from the sequencer.
   typedef struct packed {
      logic                      vec_we;
      logic                      mat_we;
      logic [IDX_W-1:0]          wr_row;
      logic [IDX_W-1:0]          wr_col;
      logic signed [VALUE_W-1:0] wr_value;
      logic [IDX_W-1:0]          rd_row;
      logic [IDX_W-1:0]          rd_col;
   } store_ctl_type;

   // Multiply-accumulate controls from the sequencer.
   typedef struct packed {
      logic clear;
      logic issue;
   } mac_ctl_type;

endpackage

FILE: hw/rtl/vmp_store.sv
// Vector and matrix storage with registered reads.
`timescale 1ns / 1ps

module vmp_store #(
   parameter int MAX_ROWS = vmp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = vmp_pkg::DEF_MAX_COLS
) (
   input  logic                               clock,
   input  vmp_pkg::store_ctl_type             ctl,
   output logic signed [vmp_pkg::VALUE_W-1:0] vec_data,
   output logic signed [vmp_pkg::VALUE_W-1:0] mat_data
);

   localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int MAT_W = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

   logic signed [vmp_pkg::VALUE_W-1:0] vec_mem [MAX_ROWS];
   logic signed [vmp_pkg::VALUE_W-1:0] mat_mem [MAT_DEPTH];
   logic signed [vmp_pkg::VALUE_W-1:0] vec_rd_ff;
   logic signed [vmp_pkg::VALUE_W-1:0] mat_rd_ff;
   logic [MAT_W-1:0] wr_addr;
   logic [MAT_W-1:0] rd_addr;

   // Row-major layout: row times the column pitch plus column.
   assign wr_addr = MAT_W'(MAT_W'(ctl.wr_row) * MAT_W'(MAX_COLS)) + MAT_W'(ctl.wr_col);
   assign rd_addr = MAT_W'(MAT_W'(ctl.rd_row) * MAT_W'(MAX_COLS)) + MAT_W'(ctl.rd_col);

   always_ff @(posedge clock) begin
      if (ctl.vec_we) begin
         vec_mem[ROW_W'(ctl.wr_row)] <= ctl.wr_value;
      end
      vec_rd_ff <= vec_mem[ROW_W'(ctl.rd_row)];
   end

   always_ff @(posedge clock) begin
      if (ctl.mat_we) begin
         mat_mem[wr_addr] <= ctl.wr_value;
      end
      mat_rd_ff <= mat_mem[rd_addr];
   end

   assign vec_data = vec_rd_ff;
   assign mat_data = mat_rd_ff;

endmodule

FILE: hw/rtl/vmp_mac.sv
// Shared multiply-accumulate unit: registered product, then 40-bit accumulator.
`timescale 1ns / 1ps

module vmp_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  vmp_pkg::mac_ctl_type               ctl,
   input  logic signed [vmp_pkg::VALUE_W-1:0] vec_data,
   input  logic signed [vmp_pkg::VALUE_W-1:0] mat_data,
   output logic signed [vmp_pkg::SUM_W-1:0]   acc
);

   logic                                read_valid_ff;
   logic                                prod_valid_ff;
   logic signed [vmp_pkg::PROD_W-1:0]   prod_ff;
   logic signed [vmp_pkg::PROD_W-1:0]   prod_in;
   logic signed [vmp_pkg::SUM_W-1:0]    acc_ff;
   logic signed [vmp_pkg::SUM_W-1:0]    acc_in;

   assign prod_in = vec_data * mat_data;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + vmp_pkg::SUM_W'(prod_ff);
      end
   end

   // The valid flags follow the issue through the store's read register and then the product register.
   always_ff @(posedge clock) begin
      if (reset) begin
         read_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         acc_ff        <= '0;
      end else begin
         read_valid_ff <= ctl.issue;
         prod_valid_ff <= read_valid_ff;
         acc_ff        <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign acc = acc_ff;

endmodule

FILE: hw/rtl/vmp_seq.sv
// Sequencer: request decode, configuration registers, row and column loop, result register.
`timescale 1ns / 1ps

module vmp_seq #(
   parameter int MAX_ROWS = vmp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = vmp_pkg::DEF_MAX_COLS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [vmp_pkg::REG_W-1:0]          csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_kind,
   input  logic [3:0]                         req_row_index,
   input  logic [3:0]                         req_col_index,
   input  logic signed [vmp_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [3:0]                         rsp_column_index,
   output logic signed [vmp_pkg::SUM_W-1:0]   rsp_sum,
   output logic                               rsp_last,
   input  logic signed [vmp_pkg::SUM_W-1:0]   acc,
   output vmp_pkg::store_ctl_type             store_ctl,
   output vmp_pkg::mac_ctl_type               mac_ctl
);

   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_LIMIT = (MAX_COLS < vmp_pkg::RESULT_LIMIT) ? MAX_COLS
                                                                   : vmp_pkg::RESULT_LIMIT;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   // Drain countdown: once it runs out, the accumulator holds the sum.
   localparam logic [1:0] DRAIN_CYCLES = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [1:0]                       drain_ff, drain_in;
   logic [ROW_W-1:0]                 row_ff, row_in;
   logic [3:0]                       col_ff, col_in;
   logic [vmp_pkg::REG_W-1:0]        row_count_ff, row_count_in;
   logic [vmp_pkg::REG_W-1:0]        column_count_ff, column_count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [3:0]                       rsp_column_index_ff;
   logic signed [vmp_pkg::SUM_W-1:0] rsp_sum_ff;
   logic                             rsp_last_ff;

   logic [vmp_pkg::CNT_W-1:0] rows_use;
   logic [vmp_pkg::REG_W-1:0] cols_use;
   logic req_fire;
   logic rsp_free;
   logic out_load;
   logic last_col;
   logic start;

   always_comb begin
      if (vmp_pkg::CNT_W'(row_count_ff) > vmp_pkg::CNT_W'(MAX_ROWS)) begin
         rows_use = vmp_pkg::CNT_W'(MAX_ROWS);
      end else begin
         rows_use = vmp_pkg::CNT_W'(row_count_ff);
      end
      if (column_count_ff > vmp_pkg::REG_W'(COL_LIMIT)) begin
         cols_use = vmp_pkg::REG_W'(COL_LIMIT);
      end else begin
         cols_use = column_count_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign last_col  = (vmp_pkg::REG_W'(col_ff) + 5'd1) == cols_use;
   assign start     = req_fire && (req_kind == vmp_pkg::KIND_START) && (cols_use != '0);

   // Loads beyond the sizes in use are dropped here.
   always_comb begin
      store_ctl.vec_we = req_fire && (req_kind == vmp_pkg::KIND_LOAD_VECTOR)
                         && (vmp_pkg::CNT_W'(req_row_index) < rows_use);
      store_ctl.mat_we = req_fire && (req_kind == vmp_pkg::KIND_LOAD_MATRIX)
                         && (vmp_pkg::CNT_W'(req_row_index) < rows_use)
                         && (vmp_pkg::REG_W'(req_col_index) < cols_use);
      store_ctl.wr_row   = vmp_pkg::IDX_W'(req_row_index);
      store_ctl.wr_col   = vmp_pkg::IDX_W'(req_col_index);
      store_ctl.wr_value = req_value;
      store_ctl.rd_row   = vmp_pkg::IDX_W'(row_ff);
      store_ctl.rd_col   = vmp_pkg::IDX_W'(col_ff);
   end

   always_comb begin
      state_in      = state_ff;
      drain_in      = drain_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      out_load      = 1'b0;
      mac_ctl.clear = 1'b0;
      mac_ctl.issue = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               col_in        = '0;
               row_in        = '0;
               mac_ctl.clear = 1'b1;
               drain_in      = DRAIN_CYCLES;
               state_in      = (rows_use == '0) ? ST_DRAIN : ST_RUN;
            end
         end
         ST_RUN: begin
            mac_ctl.issue = 1'b1;
            if (vmp_pkg::CNT_W'(row_ff) == rows_use - 7'd1) begin
               drain_in = DRAIN_CYCLES;
               state_in = ST_DRAIN;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (drain_ff != 2'd0) begin
               drain_in = drain_ff - 2'd1;
            end else if (rsp_free) begin
               out_load = 1'b1;
               if (last_col) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in        = col_ff + 4'd1;
                  row_in        = '0;
                  mac_ctl.clear = 1'b1;
                  drain_in      = DRAIN_CYCLES;
                  state_in      = (rows_use == '0) ? ST_DRAIN : ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_write_enable) begin
         if (csr_index == vmp_pkg::CSR_ROW_COUNT) begin
            row_count_in = csr_write_data;
         end else begin
            column_count_in = csr_write_data;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         drain_ff        <= '0;
         row_ff          <= '0;
         col_ff          <= '0;
         row_count_ff    <= vmp_pkg::ROW_COUNT_RESET;
         column_count_ff <= vmp_pkg::COLUMN_COUNT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         drain_ff        <= drain_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_column_index_ff <= col_ff;
         rsp_sum_ff          <= acc;
         rsp_last_ff         <= last_col;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column_index = rsp_column_index_ff;
   assign rsp_sum          = rsp_sum_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

FILE: hw/rtl/vector_matrix_product.sv
// Top level of the vector-matrix product block.
`timescale 1ns / 1ps

// Multiplies a signed Q8.8 row vector by a Q8.8 matrix held in on-chip storage.
// Load requests write one vector or matrix element each and are taken only while idle.
// A start request runs the dot products on a single multiply-accumulate unit,
// one row per cycle: for each column in use it clears the accumulator, issues
// one read per row, lets the two read/multiply stages drain and hands the sum
// to the result register, waiting while the result channel stalls. Results
// come out in column order as exact 40-bit sums with 16 fraction bits, the
// last one flagged. Only written entries may be read; loads outside the
// configured row and column counts are dropped.
module vector_matrix_product #(
   parameter int MAX_ROWS = vmp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = vmp_pkg::DEF_MAX_COLS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic                               csr_index,
   input  logic [vmp_pkg::REG_W-1:0]          csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_kind,
   input  logic [3:0]                         req_row_index,
   input  logic [3:0]                         req_col_index,
   input  logic signed [vmp_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [3:0]                         rsp_column_index,
   output logic signed [vmp_pkg::SUM_W-1:0]   rsp_sum,
   output logic                               rsp_last
);

   vmp_pkg::store_ctl_type             store_ctl;
   vmp_pkg::mac_ctl_type               mac_ctl;
   logic signed [vmp_pkg::VALUE_W-1:0] vec_data;
   logic signed [vmp_pkg::VALUE_W-1:0] mat_data;
   logic signed [vmp_pkg::SUM_W-1:0]   acc;

   vmp_seq #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column_index (rsp_column_index),
      .rsp_sum          (rsp_sum),
      .rsp_last         (rsp_last),
      .acc              (acc),
      .store_ctl        (store_ctl),
      .mac_ctl          (mac_ctl)
   );

   vmp_store #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_store (
      .clock    (clock),
      .ctl      (store_ctl),
      .vec_data (vec_data),
      .mat_data (mat_data)
   );

   vmp_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mac_ctl),
      .vec_data (vec_data),
      .mat_data (mat_data),
      .acc      (acc)
   );

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the vector-matrix product block.
`timescale 1ns / 1ps

module tb;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int STORE_ROWS     = 16;
   localparam int STORE_COLS     = 16;
   localparam int REQUEST_TARGET = 260;
   localparam int SETTLE_CYCLES  = 40;
   localparam int LIMIT_CYCLES   = 400000;

   typedef struct packed {
      logic [3:0]                       column;
      logic signed [vmp_pkg::SUM_W-1:0] sum;
      logic                             last;
   } column_sum_type;

   typedef struct packed {
      bit                               is_reg;
      logic                             reg_sel;
      logic [vmp_pkg::REG_W-1:0]        reg_data;
      logic [1:0]                       kind;
      logic [3:0]                       row;
      logic [3:0]                       col;
      logic [vmp_pkg::VALUE_W-1:0]      value;
      bit                               typed;
      logic signed [vmp_pkg::SUM_W-1:0] sum;
   } script_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_write_enable = 1'b0;
   logic                               csr_index = 1'b0;
   logic [vmp_pkg::REG_W-1:0]          csr_write_data = '0;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [1:0]                         req_kind = vmp_pkg::KIND_LOAD_VECTOR;
   logic [3:0]                         req_row_index = '0;
   logic [3:0]                         req_col_index = '0;
   logic signed [vmp_pkg::VALUE_W-1:0] req_value = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [3:0]                         rsp_column_index;
   logic signed [vmp_pkg::SUM_W-1:0]   rsp_sum;
   logic                               rsp_last;

   // Shadow copy of the block's stores and registers.
   logic signed [vmp_pkg::VALUE_W-1:0] vector_mem [STORE_ROWS];
   logic signed [vmp_pkg::VALUE_W-1:0] matrix_mem [STORE_ROWS][STORE_COLS];
   bit                                 vector_known [STORE_ROWS];
   bit                                 matrix_known [STORE_ROWS][STORE_COLS];
   logic [vmp_pkg::REG_W-1:0]          row_reg = vmp_pkg::ROW_COUNT_RESET;
   logic [vmp_pkg::REG_W-1:0]          col_reg = vmp_pkg::COLUMN_COUNT_RESET;

   column_sum_type                     pending_sums [$];
   script_row_type                     script [$];

   int unsigned                  error_count = 0;
   int unsigned                  requests_sent = 0;
   int unsigned                  live_requests = 0;
   int unsigned                  starts_sent = 0;
   int unsigned                  sums_seen = 0;
   int unsigned                  reg_writes = 0;
   int unsigned                  cycle_count = 0;
   int                           stall_left = 0;
   int                           stall_pick;
   bit                           steady = 1'b0;

   vector_matrix_product u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_row_index    (req_row_index),
      .req_col_index    (req_col_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column_index (rsp_column_index),
      .rsp_sum          (rsp_sum),
      .rsp_last         (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d column sums outstanding", $time,
                  pending_sums.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result-side back-pressure: mostly short stalls, now and then a long one.
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 70) begin
            rsp_stall <= 1'b0;
         end else if (stall_pick < 93) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            stall_left = $urandom_range(8, 30);
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_sums
      column_sum_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         sums_seen++;
         if (pending_sums.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result column %0d sum %0d last %0d", $time,
                     rsp_column_index, rsp_sum, rsp_last);
         end else begin
            want = pending_sums.pop_front();
            if (rsp_column_index !== want.column) begin
               error_count++;
               $display("%0t: column index expected %0d, got %0d", $time,
                        want.column, rsp_column_index);
            end
            if (rsp_sum !== want.sum) begin
               error_count++;
               $display("%0t: sum of column %0d expected %0d, got %0d", $time,
                        want.column, want.sum, rsp_sum);
            end
            if (rsp_last !== want.last) begin
               error_count++;
               $display("%0t: last flag of column %0d expected %0d, got %0d", $time,
                        want.column, want.last, rsp_last);
            end
         end
      end
   end

   function automatic int rows_active();
      return (row_reg > STORE_ROWS) ? STORE_ROWS : int'(row_reg);
   endfunction

   // Columns are capped by the store and by the 16 results a start can give.
   function automatic int cols_active();
      int cols;
      cols = (col_reg > STORE_COLS) ? STORE_COLS : int'(col_reg);
      return (cols > vmp_pkg::RESULT_LIMIT) ? vmp_pkg::RESULT_LIMIT : cols;
   endfunction

   // Applies an accepted request to the shadow state and queues the column
   // sums it produces. Returns whether it was a start or a load that landed.
   function automatic bit predict_request(input logic [1:0] kind, input logic [3:0] row,
                                          input logic [3:0] col,
                                          input logic signed [vmp_pkg::VALUE_W-1:0] value,
                                          input bit typed,
                                          input logic signed [vmp_pkg::SUM_W-1:0] typed_sum);
      column_sum_type item;
      longint         acc;
      case (kind)
         vmp_pkg::KIND_LOAD_VECTOR: begin
            if (row < rows_active()) begin
               vector_mem[row] = value;
               vector_known[row] = 1'b1;
               return 1'b1;
            end
         end
         vmp_pkg::KIND_LOAD_MATRIX: begin
            if (row < rows_active() && col < cols_active()) begin
               matrix_mem[row][col] = value;
               matrix_known[row][col] = 1'b1;
               return 1'b1;
            end
         end
         vmp_pkg::KIND_START: begin
            if (typed) begin
               item.column = '0;
               item.sum = typed_sum;
               item.last = 1'b1;
               pending_sums.push_back(item);
            end else begin
               for (int c = 0; c < cols_active(); c++) begin
                  acc = 0;
                  for (int r = 0; r < rows_active(); r++)
                     acc += longint'(vector_mem[r]) * longint'(matrix_mem[r][c]);
                  item.column = c[3:0];
                  item.sum = acc[vmp_pkg::SUM_W-1:0];
                  item.last = (c == cols_active() - 1);
                  pending_sums.push_back(item);
               end
            end
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic int pick_gap();
      int pick;
      if (steady)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [vmp_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic [3:0] row,
                               input logic [3:0] col,
                               input logic [vmp_pkg::VALUE_W-1:0] value,
                               input bit typed,
                               input logic signed [vmp_pkg::SUM_W-1:0] typed_sum);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_row_index <= row;
      req_col_index <= col;
      req_value <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      requests_sent++;
      if (kind == vmp_pkg::KIND_START)
         starts_sent++;
      if (predict_request(kind, row, col, value, typed, typed_sum))
         live_requests++;
   endtask

   // A start must never read an entry that was never loaded.
   task automatic fill_unwritten();
      for (int r = 0; r < rows_active(); r++)
         if (!vector_known[r])
            send_request(vmp_pkg::KIND_LOAD_VECTOR, r[3:0], 4'($urandom_range(0, 15)),
                         pick_value(), 1'b0, '0);
      for (int r = 0; r < rows_active(); r++)
         for (int c = 0; c < cols_active(); c++)
            if (!matrix_known[r][c])
               send_request(vmp_pkg::KIND_LOAD_MATRIX, r[3:0], c[3:0], pick_value(),
                            1'b0, '0);
   endtask

   task automatic start_product(input bit typed,
                                input logic signed [vmp_pkg::SUM_W-1:0] typed_sum);
      fill_unwritten();
      send_request(vmp_pkg::KIND_START, 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hFFFF)),
                   typed, typed_sum);
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_sums.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic sel, input logic [vmp_pkg::REG_W-1:0] data);
      settle_block();
      csr_write_enable <= 1'b1;
      csr_index <= sel;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (sel == vmp_pkg::CSR_ROW_COUNT)
         row_reg = data;
      else
         col_reg = data;
      reg_writes++;
   endtask

   function automatic void put_item(input logic [1:0] kind, input logic [3:0] row,
                                    input logic [3:0] col,
                                    input logic [vmp_pkg::VALUE_W-1:0] value);
      script_row_type entry;
      entry = '0;
      entry.kind = kind;
      entry.row = row;
      entry.col = col;
      entry.value = value;
      script.push_back(entry);
   endfunction

   function automatic void put_start_expect(input logic signed [vmp_pkg::SUM_W-1:0] sum);
      script_row_type entry;
      entry = '0;
      entry.kind = vmp_pkg::KIND_START;
      entry.typed = 1'b1;
      entry.sum = sum;
      script.push_back(entry);
   endfunction

   function automatic void put_reg(input logic sel, input logic [vmp_pkg::REG_W-1:0] data);
      script_row_type entry;
      entry = '0;
      entry.is_reg = 1'b1;
      entry.reg_sel = sel;
      entry.reg_data = data;
      script.push_back(entry);
   endfunction

   // Large counts are only offered when the product of both sizes stays modest.
   function automatic logic [vmp_pkg::REG_W-1:0] pick_count(input bit allow_large);
      int pick;
      pick = $urandom_range(0, 9);
      if (allow_large && pick == 0)
         return 5'd16;
      if (allow_large && pick == 1)
         return 5'($urandom_range(17, 31));
      if (pick == 2)
         return 5'd0;
      return 5'($urandom_range(1, 5));
   endfunction

   initial begin
      int          phase_len;
      int          pick;
      int          rows;
      int          cols;

      // Both loads land only if the reset sizes are in effect; the later
      // full-height start reads the vector entry back.
      put_item(vmp_pkg::KIND_LOAD_VECTOR, 4'd15, 4'd0, 16'h7FFF);
      put_item(vmp_pkg::KIND_LOAD_MATRIX, 4'd15, 4'd15, 16'h8000);
      // The column count is still at its reset value here: sixteen results.
      put_reg(vmp_pkg::CSR_ROW_COUNT, 5'd1);
      put_item(vmp_pkg::KIND_START, 4'd0, 4'd0, 16'h0000);
      put_reg(vmp_pkg::CSR_COLUMN_COUNT, 5'd1);
      put_item(vmp_pkg::KIND_LOAD_VECTOR, 4'd0, 4'd0, 16'h0100);
      put_item(vmp_pkg::KIND_LOAD_MATRIX, 4'd0, 4'd0, 16'h0100);
      put_start_expect(40'sd65536);
      put_item(vmp_pkg::KIND_LOAD_VECTOR, 4'd0, 4'd0, 16'h8000);
      put_item(vmp_pkg::KIND_LOAD_MATRIX, 4'd0, 4'd0, 16'h8000);
      put_start_expect(40'sd1073741824);
      put_item(vmp_pkg::KIND_LOAD_MATRIX, 4'd0, 4'd0, 16'h7FFF);
      put_start_expect(-40'sd1073709056);
      // Loads past the sizes in use and the spare kind must leave the stores alone.
      put_item(vmp_pkg::KIND_LOAD_VECTOR, 4'd5, 4'd0, 16'h1234);
      put_item(vmp_pkg::KIND_LOAD_MATRIX, 4'd0, 4'd3, 16'h7777);
      put_item(KIND_UNUSED, 4'd15, 4'd15, 16'hFFFF);
      put_start_expect(-40'sd1073709056);
      put_reg(vmp_pkg::CSR_ROW_COUNT, 5'd0);
      put_start_expect(40'sd0);
      put_reg(vmp_pkg::CSR_COLUMN_COUNT, 5'd0);
      put_item(vmp_pkg::KIND_START, 4'd15, 4'd15, 16'hFFFF);
      // Oversized counts clamp to the store size.
      put_reg(vmp_pkg::CSR_ROW_COUNT, 5'd31);
      put_reg(vmp_pkg::CSR_COLUMN_COUNT, 5'd1);
      put_item(vmp_pkg::KIND_START, 4'd0, 4'd0, 16'h0000);
      put_reg(vmp_pkg::CSR_ROW_COUNT, 5'd1);
      put_reg(vmp_pkg::CSR_COLUMN_COUNT, 5'd20);
      put_item(vmp_pkg::KIND_START, 4'd0, 4'd0, 16'h0000);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].is_reg)
            write_reg(script[i].reg_sel, script[i].reg_data);
         else if (script[i].kind == vmp_pkg::KIND_START)
            start_product(script[i].typed, script[i].sum);
         else
            send_request(script[i].kind, script[i].row, script[i].col, script[i].value,
                         1'b0, '0);
      end

      // Random phases: new sizes, then loads with random content, spare-kind requests and starts.
      while (requests_sent < REQUEST_TARGET) begin
         write_reg(vmp_pkg::CSR_ROW_COUNT, pick_count(1'b1));
         write_reg(vmp_pkg::CSR_COLUMN_COUNT, pick_count(rows_active() <= 5));
         steady = ($urandom_range(0, 3) == 0);
         rows = rows_active();
         cols = cols_active();
         phase_len = $urandom_range(10, 30);
         for (int k = 0; k < phase_len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
               send_request(KIND_UNUSED, 4'($urandom_range(0, 15)),
                            4'($urandom_range(0, 15)), 16'($urandom_range(0, 16'hFFFF)),
                            1'b0, '0);
            else if (pick < 12)
               send_request(2'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                            4'($urandom_range(0, 15)), pick_value(), 1'b0, '0);
            else if (pick < 25)
               start_product(1'b0, '0);
            else if (rows == 0 || cols == 0)
               send_request(2'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                            4'($urandom_range(0, 15)), pick_value(), 1'b0, '0);
            else
               send_request(2'($urandom_range(0, 1)), 4'($urandom_range(0, rows - 1)),
                            4'($urandom_range(0, cols - 1)), pick_value(), 1'b0, '0);
         end
         start_product(1'b0, '0);
      end

      settle_block();
      steady = 1'b0;
      $display("Sent %0d requests (%0d starts, %0d that took effect) over %0d register writes;",
               requests_sent, starts_sent, live_requests, reg_writes);
      $display("checked %0d column sums, %0d mismatches.", sums_seen, error_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: vector_matrix_product.f
hw/rtl/vmp_pkg.sv
hw/rtl/vmp_store.sv
hw/rtl/vmp_mac.sv
hw/rtl/vmp_seq.sv
hw/rtl/vector_matrix_product.sv
tb/sv/tb.sv
